// ===== src/cptp_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// cptp_pkg
// Types, character codes and classifiers shared by the char pair token packer.
// ----------------------------------------------------------------------------
package cptp_pkg;

    localparam logic [7:0] CHAR_TAB      = 8'h09;
    localparam logic [7:0] CHAR_NEWLINE  = 8'h0A;
    localparam logic [7:0] CHAR_SPACE    = 8'h20;
    localparam logic [7:0] CHAR_BANG     = 8'h21;
    localparam logic [7:0] CHAR_PERCENT  = 8'h25;
    localparam logic [7:0] CHAR_AMP      = 8'h26;
    localparam logic [7:0] CHAR_STAR     = 8'h2A;
    localparam logic [7:0] CHAR_PLUS     = 8'h2B;
    localparam logic [7:0] CHAR_MINUS    = 8'h2D;
    localparam logic [7:0] CHAR_SLASH    = 8'h2F;
    localparam logic [7:0] CHAR_LT       = 8'h3C;
    localparam logic [7:0] CHAR_GT       = 8'h3E;
    localparam logic [7:0] CHAR_UP_A     = 8'h41;
    localparam logic [7:0] CHAR_UP_Z     = 8'h5A;
    localparam logic [7:0] CHAR_CARET    = 8'h5E;
    localparam logic [7:0] CHAR_USCORE   = 8'h5F;
    localparam logic [7:0] CHAR_LO_A     = 8'h61;
    localparam logic [7:0] CHAR_LO_Z     = 8'h7A;
    localparam logic [7:0] CHAR_BAR      = 8'h7C;

    localparam logic [1:0] WINDOW_FULL   = 2'd2;
    localparam logic [2:0] SLOT_OVERFLOW = 3'd4;
    localparam int         NUM_PUSH      = 3;

    typedef struct packed {
        logic [7:0]  la0;
        logic [7:0]  la1;
        logic [1:0]  fill;
        logic        skip;
        logic [63:0] acc;
        logic [1:0]  slot;
    } cptp_state_t;

    typedef struct packed {
        logic        valid;
        logic [63:0] word;
        logic        cont;
    } cptp_result_t;

    typedef struct packed {
        logic [63:0] word;
        logic        cont;
        logic        last;
    } cptp_entry_t;

    localparam cptp_state_t STATE_RESET = '{
        la0:  CHAR_SPACE,
        la1:  CHAR_SPACE,
        fill: 2'd0,
        skip: 1'b0,
        acc:  64'd0,
        slot: 2'd0
    };

    function automatic logic is_ws(input logic [7:0] c);
        return (c == CHAR_TAB) || (c == CHAR_NEWLINE) || (c == CHAR_SPACE);
    endfunction

    function automatic logic is_ident_char(input logic [7:0] c);
        return ((c >= CHAR_UP_A) && (c <= CHAR_UP_Z)) ||
               ((c >= CHAR_LO_A) && (c <= CHAR_LO_Z)) || (c == CHAR_USCORE);
    endfunction

    function automatic logic op_first(input logic [7:0] c);
        return (c == CHAR_BANG) || (c == CHAR_PERCENT) || (c == CHAR_AMP) ||
               (c == CHAR_STAR) || (c == CHAR_PLUS) || (c == CHAR_CARET) ||
               (c == CHAR_BAR) || ((c >= CHAR_MINUS) && (c <= CHAR_SLASH)) ||
               ((c >= CHAR_LT) && (c <= CHAR_GT));
    endfunction

    function automatic logic op_second(input logic [7:0] c);
        return (c == CHAR_STAR) || (c == CHAR_PLUS) || (c == CHAR_BAR) ||
               (c == CHAR_AMP) || (c == CHAR_MINUS) ||
               ((c >= CHAR_LT) && (c <= CHAR_GT));
    endfunction

endpackage
`default_nettype wire

// ===== src/char_pair_token_packer.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// char_pair_token_packer
// Scans a byte stream through a three-byte window and packs pair codes into
// 64-bit token words.
// ----------------------------------------------------------------------------
//  channel  | dir | tdata                  | tuser      | tlast
//  s_axis   | in  | char_byte[7:0]         | -          | end_of_input
//  m_axis   | out | token_word[63:0]       | continued  | last_of_run
//
//  One request per cycle while s_axis_tready is high; results appear the cycle after acceptance.
//  A request gives 0 to 3 results; the queue drains one per cycle while the
//  receiver is ready; s_axis_tready stays low until the last one leaves.
//  The three byte steps (byte, two pad spaces) are chained combinationally.
//  Reset clears the window to spaces and empties the queue; end_of_input
//  returns the scanner to its reset state after the pad steps.
// ----------------------------------------------------------------------------
module char_pair_token_packer (
    input  wire         clk,
    input  wire         rst_n,
    input  wire         s_axis_tvalid,
    output logic        s_axis_tready,
    input  wire [7:0]   s_axis_tdata,   // [7:0] char_byte
    input  wire         s_axis_tlast,
    output logic        m_axis_tvalid,
    input  wire         m_axis_tready,
    output logic [63:0] m_axis_tdata,   // [63:0] token_word
    output logic        m_axis_tuser,   // [0] continued
    output logic        m_axis_tlast
);
    import cptp_pkg::*;

    cptp_state_t             state_reg;
    cptp_state_t             state_next;
    cptp_state_t             st1;
    cptp_state_t             st2;
    cptp_state_t             st3;
    cptp_result_t            r0;
    cptp_result_t            r1;
    cptp_result_t            r2;
    cptp_result_t [2:0]      res;
    cptp_entry_t             head;
    logic                    accept;

    assign accept = s_axis_tvalid && s_axis_tready;

    cptp_push u_push0 (.state_in(state_reg), .byte_in(s_axis_tdata), .state_out(st1), .res(r0));
    cptp_push u_push1 (.state_in(st1), .byte_in(CHAR_SPACE), .state_out(st2), .res(r1));
    cptp_push u_push2 (.state_in(st2), .byte_in(CHAR_SPACE), .state_out(st3), .res(r2));

    always_comb
    begin
        res[0]       = r0;
        res[1]       = r1;
        res[2]       = r2;
        res[1].valid = r1.valid && s_axis_tlast;
        res[2].valid = r2.valid && s_axis_tlast;
        state_next   = s_axis_tlast ? STATE_RESET : st1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= STATE_RESET;
        end
        else if (accept)
        begin
            state_reg <= state_next;
        end
    end

    cptp_outq u_outq (
        .clk       (clk),
        .rst_n     (rst_n),
        .load      (accept),
        .res       (res),
        .pop       (m_axis_tready),
        .can_load  (s_axis_tready),
        .out_valid (m_axis_tvalid),
        .out_entry (head)
    );

    assign m_axis_tdata = head.word;
    assign m_axis_tuser = head.cont;
    assign m_axis_tlast = head.last;

endmodule
`default_nettype wire

// ===== src/cptp_push.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// cptp_push
// One byte step: window shift, pair classification and slot packing.
// ----------------------------------------------------------------------------
module cptp_push (
    input  wire cptp_pkg::cptp_state_t  state_in,
    input  wire logic [7:0]             byte_in,
    output cptp_pkg::cptp_state_t       state_out,
    output cptp_pkg::cptp_result_t      res
);
    import cptp_pkg::*;

    logic [7:0]  x;
    logic [7:0]  y;
    logic        nws;
    logic        lpair;
    logic        opair;
    logic [15:0] val;
    logic [63:0] acc_or;
    logic [2:0]  slot_n;

    assign x      = state_in.la0;
    assign y      = state_in.la1;
    assign nws    = !is_ws(x);
    assign lpair  = is_ident_char(x) && is_ident_char(y);
    assign opair  = op_first(x) && op_second(y);
    assign val    = nws ? (({8'd0, x} << 7) + ((lpair || opair) ? {8'd0, y} : 16'd0))
                        : 16'd0;
    assign acc_or = state_in.acc | ({48'd0, val} << {state_in.slot, 4'd0});
    assign slot_n = (lpair && is_ident_char(byte_in)) ? ({1'b0, state_in.slot} + 3'd1)
                                                      : 3'd0;

    always_comb
    begin
        state_out     = state_in;
        state_out.la0 = state_in.la1;
        state_out.la1 = byte_in;
        res           = '{valid: 1'b0, word: acc_or, cont: 1'b0};
        if (state_in.fill != WINDOW_FULL)
        begin
            state_out.fill = state_in.fill + 2'd1;
        end
        else if (state_in.skip)
        begin
            state_out.skip = 1'b0;
        end
        else
        begin
            state_out.acc = acc_or;
            if (slot_n == SLOT_OVERFLOW)
            begin
                res.valid      = 1'b1;
                res.cont       = 1'b1;
                state_out.acc  = 64'd0;
                state_out.slot = 2'd0;
            end
            else
            begin
                state_out.slot = slot_n[1:0];
                if ((slot_n == 3'd0) && nws)
                begin
                    res.valid     = 1'b1;
                    state_out.acc = 64'd0;
                end
            end
            if (is_ws(y) || lpair || opair)
            begin
                state_out.skip = 1'b1;
            end
        end
    end

endmodule
`default_nettype wire

// ===== src/cptp_outq.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// cptp_outq
// Result queue: packs up to three step results of a request and drains them.
// ----------------------------------------------------------------------------
module cptp_outq (
    input  wire                                 clk,
    input  wire                                 rst_n,
    input  wire logic                           load,
    input  wire cptp_pkg::cptp_result_t [2:0]   res,
    input  wire logic                           pop,
    output logic                                can_load,
    output logic                                out_valid,
    output cptp_pkg::cptp_entry_t               out_entry
);
    import cptp_pkg::*;

    cptp_entry_t q_reg [NUM_PUSH];
    cptp_entry_t q_next [NUM_PUSH];
    logic [1:0]  cnt_reg;
    logic [1:0]  cnt_next;
    logic [1:0]  n_new;

    assign out_valid = (cnt_reg != 2'd0);
    assign out_entry = q_reg[0];
    assign can_load  = (cnt_reg == 2'd0) || ((cnt_reg == 2'd1) && pop);

    always_comb
    begin
        n_new = 2'd0;
        for (int i = 0; i < NUM_PUSH; i++)
        begin
            q_next[i] = '{word: 64'd0, cont: 1'b0, last: 1'b0};
        end
        for (int i = 0; i < NUM_PUSH; i++)
        begin
            if (res[i].valid)
            begin
                q_next[n_new] = '{word: res[i].word, cont: res[i].cont, last: 1'b0};
                n_new         = n_new + 2'd1;
            end
        end
        if (n_new != 2'd0)
        begin
            q_next[n_new - 2'd1].last = 1'b1;
        end
        cnt_next = n_new;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= 2'd0;
        end
        else if (load)
        begin
            cnt_reg <= cnt_next;
        end
        else if (pop && out_valid)
        begin
            cnt_reg <= cnt_reg - 2'd1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            q_reg <= q_next;
        end
        else if (pop && out_valid)
        begin
            q_reg[0] <= q_reg[1];
            q_reg[1] <= q_reg[2];
        end
    end

endmodule
`default_nettype wire

// ===== src/cptp_checker.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// cptp_checker
// Port-level checks for the char pair token packer.
// ----------------------------------------------------------------------------
module cptp_checker (
    input wire          clk,
    input wire          rst_n,
    input wire          s_axis_tvalid,
    input wire          s_axis_tready,
    input wire [7:0]    s_axis_tdata,
    input wire          s_axis_tlast,
    input wire          m_axis_tvalid,
    input wire          m_axis_tready,
    input wire [63:0]   m_axis_tdata,
    input wire          m_axis_tuser,
    input wire          m_axis_tlast
);

    // stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && !m_axis_tready) |=>
        (m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser) &&
         $stable(m_axis_tlast)))
        else $error("stalled result changed");

    // waiting request holds its byte
    a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (s_axis_tvalid && !s_axis_tready) |=>
        (s_axis_tvalid && $stable(s_axis_tdata) && $stable(s_axis_tlast)))
        else $error("waiting request changed");

    // no new request while a stalled result waits
    a_no_accept_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && !m_axis_tready) |-> !s_axis_tready)
        else $error("request accepted while output stalled");

    // results of one request come back to back
    a_run_contiguous: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && m_axis_tready && !m_axis_tlast) |=> m_axis_tvalid)
        else $error("gap inside a result run");

    // a byte that is not the end of input gives at most one result
    a_single_result: assert property (@(posedge clk) disable iff (!rst_n)
        (s_axis_tvalid && s_axis_tready && !s_axis_tlast) |=>
        (!m_axis_tvalid || m_axis_tlast))
        else $error("more than one result for a mid-stream byte");

endmodule

bind char_pair_token_packer cptp_checker u_cptp_checker (.*);
`default_nettype wire

// ===== test/tb_top.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the char pair token packer. Source bytes go in on
// the slave stream; every token word coming out is checked against a local
// scan of the same bytes (three-byte window, pair codes, slot packing, end of
// input padding). Directed streams come first, then random streams under
// three idle patterns and one long receiver hold-off.
// ----------------------------------------------------------------------------
module tb_top;
    import cptp_pkg::*;

    localparam int CLOCK_PERIOD   = 10;
    localparam int LIMIT_CYCLES   = 200000;
    localparam int DRAIN_CYCLES   = 8;
    localparam int RANDOM_ITEMS   = 270;
    localparam int HOLD_CYCLES    = 80;
    localparam int MAX_REPORTS    = 10;

    localparam logic [7:0] CHAR_DOT    = 8'h2E;
    localparam logic [7:0] CHAR_EQUAL  = 8'h3D;
    localparam logic [7:0] CHAR_SEMI   = 8'h3B;
    localparam logic [7:0] CHAR_LPAREN = 8'h28;
    localparam logic [7:0] CHAR_RPAREN = 8'h29;
    localparam logic [7:0] CHAR_COMMA  = 8'h2C;
    localparam logic [7:0] CHAR_MAX    = 8'hFF;
    localparam logic [7:0] CHAR_NUL    = 8'h00;

    // ------------------------------------------------------------------
    // scoreboard: scans accepted bytes and holds the token words they owe
    // ------------------------------------------------------------------
    class token_scoreboard;
        typedef struct {
            logic [63:0] word;
            logic        cont;
            logic        last;
        } token_t;

        logic [7:0]  held_bytes [2];
        logic [1:0]  bytes_held;
        logic        skip_next;
        logic [63:0] word_acc;
        logic [1:0]  slot_idx;

        token_t      run_q[$];
        token_t      token_q[$];

        int          failures;
        int          words_checked;
        int          split_words;
        int          bytes_seen;
        int          streams_seen;

        function new();
            restart();
            failures      = 0;
            words_checked = 0;
            split_words   = 0;
            bytes_seen    = 0;
            streams_seen  = 0;
        endfunction

        function void restart();
            held_bytes[0] = CHAR_SPACE;
            held_bytes[1] = CHAR_SPACE;
            bytes_held    = 2'd0;
            skip_next     = 1'b0;
            word_acc      = 64'd0;
            slot_idx      = 2'd0;
        endfunction

        function logic blank_char(logic [7:0] c);
            return c == CHAR_TAB || c == CHAR_NEWLINE || c == CHAR_SPACE;
        endfunction

        function logic word_char(logic [7:0] c);
            return c == CHAR_USCORE || (c >= CHAR_UP_A && c <= CHAR_UP_Z) ||
                   (c >= CHAR_LO_A && c <= CHAR_LO_Z);
        endfunction

        function logic op_lead(logic [7:0] c);
            case (c)
                CHAR_BANG, CHAR_PERCENT, CHAR_AMP, CHAR_STAR, CHAR_PLUS,
                CHAR_CARET, CHAR_BAR, CHAR_MINUS, CHAR_DOT, CHAR_SLASH,
                CHAR_LT, CHAR_EQUAL, CHAR_GT: return 1'b1;
                default: return 1'b0;
            endcase
        endfunction

        function logic op_tail(logic [7:0] c);
            case (c)
                CHAR_STAR, CHAR_PLUS, CHAR_BAR, CHAR_AMP, CHAR_MINUS,
                CHAR_LT, CHAR_EQUAL, CHAR_GT: return 1'b1;
                default: return 1'b0;
            endcase
        endfunction

        function void emit(logic [63:0] w, logic c);
            run_q.push_back('{word: w, cont: c, last: 1'b0});
        endfunction

        function void scan_position(logic [7:0] x, logic [7:0] y, logic [7:0] z);
            logic        letters;
            logic        op;
            logic [15:0] code;
            logic [2:0]  next_slot;
            letters = word_char(x) && word_char(y);
            op      = op_lead(x) && op_tail(y);
            code    = 16'd0;
            if (!blank_char(x))
                code = {1'b0, x, 7'd0} + ((letters || op) ? {8'd0, y} : 16'd0);
            word_acc |= {48'd0, code} << {slot_idx, 4'b0000};
            next_slot = (letters && word_char(z)) ? {1'b0, slot_idx} + 3'd1 : 3'd0;
            if (next_slot == 3'd4)
            begin
                // run too long for one word: flush it as continued
                emit(word_acc, 1'b1);
                word_acc = 64'd0;
                slot_idx = 2'd0;
            end
            else
            begin
                slot_idx = next_slot[1:0];
                if (next_slot == 3'd0 && !blank_char(x))
                begin
                    emit(word_acc, 1'b0);
                    word_acc = 64'd0;
                end
            end
            if (blank_char(y) || letters || op)
                skip_next = 1'b1;
        endfunction

        function void shift_in(logic [7:0] z);
            if (bytes_held < WINDOW_FULL)
                bytes_held++;
            else if (skip_next)
                skip_next = 1'b0;
            else
                scan_position(held_bytes[0], held_bytes[1], z);
            held_bytes[0] = held_bytes[1];
            held_bytes[1] = z;
        endfunction

        function void note_char(logic [7:0] c, logic eoi);
            run_q.delete();
            bytes_seen++;
            shift_in(c);
            if (eoi)
            begin
                shift_in(CHAR_SPACE);
                shift_in(CHAR_SPACE);
                restart();
                streams_seen++;
            end
            if (run_q.size() > 0)
                run_q[run_q.size() - 1].last = 1'b1;
            foreach (run_q[i])
                token_q.push_back(run_q[i]);
        endfunction

        function void report(string what, logic [63:0] w, logic c, logic l, token_t e);
            failures++;
            if (failures <= MAX_REPORTS)
                $display("[%0t] %s: got word=%h cont=%b last=%b, exp word=%h cont=%b last=%b",
                         $time, what, w, c, l, e.word, e.cont, e.last);
        endfunction

        function void check_word(logic [63:0] w, logic c, logic l);
            token_t e;
            if (token_q.size() == 0)
            begin
                e = '{word: 64'd0, cont: 1'b0, last: 1'b0};
                report("unexpected token word", w, c, l, e);
            end
            else
            begin
                e = token_q.pop_front();
                words_checked++;
                if (e.cont)
                    split_words++;
                if (w !== e.word || c !== e.cont || l !== e.last)
                    report("token word mismatch", w, c, l, e);
            end
        endfunction

        function int pending();
            return token_q.size();
        endfunction

        function void close();
            token_t e;
            while (token_q.size() > 0)
            begin
                e = token_q.pop_front();
                report("token word never arrived", 64'd0, 1'b0, 1'b0, e);
            end
        endfunction
    endclass

    logic        clk;
    logic        rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata;      // [7:0] char_byte
    logic        s_axis_tlast;
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [63:0] m_axis_tdata;      // [63:0] token_word
    logic        m_axis_tuser;      // [0] continued
    logic        m_axis_tlast;

    token_scoreboard sb;
    int          send_idle_pct;
    int          recv_idle_pct;
    int          items_offered;
    int          cycle_count;
    bit          hold_request;

    char_pair_token_packer uut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    initial
    begin
        clk = 1'b0;
        forever #(CLOCK_PERIOD / 2) clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= LIMIT_CYCLES)
        begin
            $display("timeout after %0d cycles", cycle_count);
            $display("simulation failed");
            $finish;
        end
    end

    // both handshakes are sampled here, inputs before outputs
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (s_axis_tvalid && s_axis_tready)
                sb.note_char(s_axis_tdata, s_axis_tlast);
            if (m_axis_tvalid && m_axis_tready)
                sb.check_word(m_axis_tdata, m_axis_tuser, m_axis_tlast);
        end
    end

    // receiver: random stalls, or one long hold-off on request
    initial
    begin
        int held;
        m_axis_tready <= 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (hold_request)
            begin
                m_axis_tready <= 1'b0;
                for (held = 0; held < HOLD_CYCLES; held++)
                    @(posedge clk);
                hold_request = 1'b0;
            end
            else
                m_axis_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
        end
    end

    task automatic push_char(input logic [7:0] c, input logic eoi);
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            s_axis_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= c;
        s_axis_tlast  <= eoi;
        do
            @(posedge clk);
        while (!s_axis_tready);
        items_offered++;
    endtask

    task automatic push_text(input string s, input logic eoi);
        int i;
        for (i = 0; i < s.len(); i++)
            push_char(s[i], eoi && (i == s.len() - 1));
    endtask

    function automatic logic [7:0] random_letter();
        int r;
        r = $urandom_range(0, 52);
        if (r == 52)
            return CHAR_USCORE;
        else if (r < 26)
            return CHAR_UP_A + 8'(r);
        else
            return CHAR_LO_A + 8'(r - 26);
    endfunction

    function automatic logic [7:0] random_char();
        logic [7:0] punct [17] = '{CHAR_BANG, CHAR_PERCENT, CHAR_AMP, CHAR_STAR,
                                   CHAR_PLUS, CHAR_MINUS, CHAR_DOT, CHAR_SLASH,
                                   CHAR_LT, CHAR_EQUAL, CHAR_GT, CHAR_CARET,
                                   CHAR_BAR, CHAR_SEMI, CHAR_LPAREN,
                                   CHAR_RPAREN, CHAR_COMMA};
        logic [7:0] blanks [3] = '{CHAR_TAB, CHAR_NEWLINE, CHAR_SPACE};
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 45)
            return random_letter();
        else if (pick < 67)
            return punct[$urandom_range(0, 16)];
        else if (pick < 82)
            return blanks[$urandom_range(0, 2)];
        else
            return 8'($urandom_range(0, 255));
    endfunction

    task automatic random_stream();
        int len;
        int burst;
        int i;
        len = $urandom_range(1, 20);
        // long identifiers now and then to force continued words
        if ($urandom_range(0, 3) == 0)
        begin
            burst = $urandom_range(8, 18);
            for (i = 0; i < burst; i++)
                push_char(random_letter(), 1'b0);
        end
        for (i = 0; i < len; i++)
            push_char(random_char(), i == len - 1);
    endtask

    initial
    begin
        int  first_random;
        bit  hold_done;
        sb             = new();
        rst_n         <= 1'b0;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata  <= 8'd0;
        s_axis_tlast  <= 1'b0;
        send_idle_pct  = 30;
        recv_idle_pct  = 74;
        items_offered  = 0;
        cycle_count    = 0;
        hold_request   = 1'b0;
        hold_done      = 1'b0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        // directed streams
        push_text("\t", 1'b1);
        push_text("(;)", 1'b1);
        push_text("abcdefghijk", 1'b1);
        push_text("a<=b\n", 1'b0);
        push_char(CHAR_MAX, 1'b0);
        push_char(CHAR_NUL, 1'b0);
        push_text("!=_", 1'b1);

        first_random = items_offered;
        while (items_offered - first_random < RANDOM_ITEMS)
        begin
            if (items_offered - first_random < RANDOM_ITEMS / 3)
            begin
                send_idle_pct = 30;
                recv_idle_pct = 74;
            end
            else if (items_offered - first_random < 2 * RANDOM_ITEMS / 3)
            begin
                send_idle_pct = 74;
                recv_idle_pct = 30;
            end
            else
            begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
                if (!hold_done)
                begin
                    hold_request = 1'b1;
                    hold_done    = 1'b1;
                end
            end
            random_stream();
        end
        s_axis_tvalid <= 1'b0;

        while (sb.pending() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        sb.close();

        $display("scanned %0d source bytes in %0d streams", sb.bytes_seen, sb.streams_seen);
        $display("checked %0d token words, %0d of them continued, %0d failures",
                 sb.words_checked, sb.split_words, sb.failures);
        if (sb.failures == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule

// ===== sim.f =====
src/cptp_pkg.sv
src/cptp_push.sv
src/cptp_outq.sv
src/char_pair_token_packer.sv
src/cptp_checker.sv
test/tb_top.sv
